### rtl/bts_pkg.sv
// Shared types and constants of the bilinear texture sampler.
// Depends on nothing; every other file imports it.
package bts_pkg;
   localparam int MAX_SIDE   = 256;
   localparam int MAX_TEXELS = 65536;
   localparam int SIDE_W     = $clog2(MAX_SIDE);
   localparam int ADDR_W     = $clog2(MAX_TEXELS);
   localparam int REG_W      = 9;
   localparam int COORD_W    = 18;
   localparam int CQ_W       = 16;
   localparam int FRAC_W     = 8;
   localparam int WEIGHT_W   = 2 * FRAC_W + 1;
   localparam int CLR_W      = 8;
   localparam int OUT_W      = 16;
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int QCNT_W     = QPTR_W + 1;
   localparam logic [OUT_W-1:0] GREY_OUT = 16'd45696;

   typedef enum logic {OP_WRITE = 1'b0, OP_SAMPLE = 1'b1} op_type;
   typedef enum logic {REG_WIDTH = 1'b0, REG_HEIGHT = 1'b1} reg_type;

   typedef struct packed {
      op_type                op;
      logic                  grey;
      logic [ADDR_W-1:0]     addr_a;
      logic [ADDR_W-1:0]     addr_b;
      logic [ADDR_W-1:0]     addr_c;
      logic [ADDR_W-1:0]     addr_d;
      logic [3*CLR_W-1:0]    texel;
      logic [WEIGHT_W-1:0]   wt_a;
      logic [WEIGHT_W-1:0]   wt_b;
      logic [WEIGHT_W-1:0]   wt_c;
      logic [WEIGHT_W-1:0]   wt_d;
   } work_type;
endpackage

### rtl/bts_front.sv
// Front end: size registers, coordinate clamp and scale, corner addresses and weights.
// Depends on bts_pkg.
module bts_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  bts_pkg::op_type             op,
   input  logic                        grey_override,
   input  logic [bts_pkg::ADDR_W-1:0]  texel_addr,
   input  logic [3*bts_pkg::CLR_W-1:0] texel_rgb,
   input  logic [bts_pkg::COORD_W-1:0] u_coord,
   input  logic [bts_pkg::COORD_W-1:0] v_coord,
   input  logic                        csr_we,
   input  bts_pkg::reg_type            csr_addr,
   input  logic [bts_pkg::REG_W-1:0]   csr_wdata,
   input  logic [bts_pkg::QCNT_W-1:0]  q_count,
   output logic                        push,
   output bts_pkg::work_type           push_data
);
   import bts_pkg::*;

   localparam int P_W = CQ_W + SIDE_W;

   function automatic logic [CQ_W-1:0] clamp_coord(input logic [COORD_W-1:0] c);
      logic [CQ_W-1:0] r;
      if (c[COORD_W-1]) r = '0;
      else if (c > COORD_W'(1 << 15)) r = CQ_W'(1 << 15);
      else r = c[CQ_W-1:0];
      return r;
   endfunction

   function automatic logic [REG_W-1:0] side_of(input logic [REG_W-1:0] r);
      logic [REG_W-1:0] s;
      if (r == '0) s = REG_W'(1);
      else if (r > REG_W'(MAX_SIDE)) s = REG_W'(MAX_SIDE);
      else s = r;
      return s;
   endfunction

   logic [REG_W-1:0]   width_ff, height_ff;
   logic [REG_W-1:0]   w_side, h_side, w_m1, h_m1;

   logic               f1_valid_ff;
   op_type             f1_op_ff;
   logic               f1_grey_ff;
   logic [ADDR_W-1:0]  f1_addr_ff;
   logic [3*CLR_W-1:0] f1_texel_ff;
   logic [P_W-1:0]     f1_px_ff, f1_py_ff;
   logic [P_W-1:0]     px_in, py_in;

   logic               f2_valid_ff;
   op_type             f2_op_ff;
   logic               f2_grey_ff;
   logic [ADDR_W-1:0]  f2_addr_ff;
   logic [3*CLR_W-1:0] f2_texel_ff;
   logic [SIDE_W-1:0]  f2_xl_ff, f2_xh_ff;
   logic [ADDR_W-1:0]  f2_rowl_ff, f2_rowh_ff;
   logic [WEIGHT_W-1:0] f2_wa_ff, f2_wb_ff, f2_wc_ff, f2_wd_ff;

   logic [SIDE_W-1:0]  xl, xh, yl, yh;
   logic [FRAC_W-1:0]  s, t;
   logic [FRAC_W:0]    s_inv, t_inv;
   logic [SIDE_W+REG_W-1:0] rowl_full, rowh_full;
   logic [2*FRAC_W+1:0] wa_full, wb_full, wc_full, wd_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= REG_W'(1);
         height_ff <= REG_W'(1);
      end else if (csr_we) begin
         if (csr_addr == REG_WIDTH) width_ff <= csr_wdata;
         else height_ff <= csr_wdata;
      end
   end

   always_comb begin
      w_side = side_of(width_ff);
      h_side = side_of(height_ff);
      w_m1   = w_side - REG_W'(1);
      h_m1   = h_side - REG_W'(1);
      px_in  = P_W'(clamp_coord(u_coord)) * P_W'(w_m1[SIDE_W-1:0]);
      py_in  = P_W'(clamp_coord(v_coord)) * P_W'(h_m1[SIDE_W-1:0]);
   end

   assign in_ready = (QCNT_W'(f1_valid_ff) + QCNT_W'(f2_valid_ff) + q_count) < QCNT_W'(QDEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= in_valid && in_ready;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_comb begin
      xl = f1_px_ff[15+SIDE_W-1:15];
      s  = f1_px_ff[14:7];
      xh = xl + SIDE_W'(s != '0);
      yl = f1_py_ff[15+SIDE_W-1:15];
      t  = f1_py_ff[14:7];
      yh = yl + SIDE_W'(t != '0);
      s_inv = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, s};
      t_inv = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, t};
      rowl_full = (SIDE_W+REG_W)'(yl) * (SIDE_W+REG_W)'(w_side);
      rowh_full = (SIDE_W+REG_W)'(yh) * (SIDE_W+REG_W)'(w_side);
      wa_full = (2*FRAC_W+2)'(s_inv) * (2*FRAC_W+2)'(t_inv);
      wb_full = (2*FRAC_W+2)'(s) * (2*FRAC_W+2)'(t_inv);
      wc_full = (2*FRAC_W+2)'(s) * (2*FRAC_W+2)'(t);
      wd_full = (2*FRAC_W+2)'(s_inv) * (2*FRAC_W+2)'(t);
   end

   always_ff @(posedge clock) begin
      f1_op_ff    <= op;
      f1_grey_ff  <= grey_override;
      f1_addr_ff  <= texel_addr;
      f1_texel_ff <= texel_rgb;
      f1_px_ff    <= px_in;
      f1_py_ff    <= py_in;
      f2_op_ff    <= f1_op_ff;
      f2_grey_ff  <= f1_grey_ff;
      f2_addr_ff  <= f1_addr_ff;
      f2_texel_ff <= f1_texel_ff;
      f2_xl_ff    <= xl;
      f2_xh_ff    <= xh;
      f2_rowl_ff  <= rowl_full[ADDR_W-1:0];
      f2_rowh_ff  <= rowh_full[ADDR_W-1:0];
      f2_wa_ff    <= wa_full[WEIGHT_W-1:0];
      f2_wb_ff    <= wb_full[WEIGHT_W-1:0];
      f2_wc_ff    <= wc_full[WEIGHT_W-1:0];
      f2_wd_ff    <= wd_full[WEIGHT_W-1:0];
   end

   always_comb begin
      push = f2_valid_ff;
      push_data.op     = f2_op_ff;
      push_data.grey   = f2_grey_ff;
      push_data.texel  = f2_texel_ff;
      push_data.addr_b = f2_rowl_ff + ADDR_W'(f2_xh_ff);
      push_data.addr_c = f2_rowh_ff + ADDR_W'(f2_xh_ff);
      push_data.addr_d = f2_rowh_ff + ADDR_W'(f2_xl_ff);
      push_data.wt_a   = f2_wa_ff;
      push_data.wt_b   = f2_wb_ff;
      push_data.wt_c   = f2_wc_ff;
      push_data.wt_d   = f2_wd_ff;
      if (f2_op_ff == OP_WRITE) push_data.addr_a = f2_addr_ff;
      else push_data.addr_a = f2_rowl_ff + ADDR_W'(f2_xl_ff);
   end
endmodule

### rtl/bts_queue.sv
// Short queue of work items between the front end and the back end.
// Depends on bts_pkg.
module bts_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  bts_pkg::work_type          push_data,
   input  logic                       pop,
   output logic                       not_empty,
   output bts_pkg::work_type          head,
   output logic [bts_pkg::QCNT_W-1:0] count
);
   import bts_pkg::*;

   work_type          entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   assign not_empty = count_ff != '0;
   assign head      = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < QCNT_W'(QDEPTH)))
      else $error("queue pushed while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue popped while empty");
   a_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue count lost a push");
endmodule

### rtl/bts_back.sv
// Back end: texture store, four texel fetch, bilinear blend and result register.
// Depends on bts_pkg.
module bts_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_not_empty,
   input  bts_pkg::work_type          q_head,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [bts_pkg::OUT_W-1:0]  red_out,
   output logic [bts_pkg::OUT_W-1:0]  green_out,
   output logic [bts_pkg::OUT_W-1:0]  blue_out
);
   import bts_pkg::*;

   localparam int PROD_W = CLR_W + WEIGHT_W;

   logic [3*CLR_W-1:0] store_lo [MAX_TEXELS];
   logic [3*CLR_W-1:0] store_hi [MAX_TEXELS];

   logic                en;
   logic                s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic                s1_grey_ff, s2_grey_ff;
   logic [3*CLR_W-1:0]  ta_ff, tb_ff, tc_ff, td_ff;
   logic [WEIGHT_W-1:0] wa_ff, wb_ff, wc_ff, wd_ff;
   logic [PROD_W-1:0]   pa_ff [3], pb_ff [3], pc_ff [3], pd_ff [3];
   logic [PROD_W-1:0]   pa_in [3], pb_in [3], pc_in [3], pd_in [3];
   logic [OUT_W-1:0]    res_ff [3], res_in [3];
   logic [PROD_W+1:0]   sum [3];

   assign en    = !out_valid_ff || rsp_ready;
   assign q_pop = en && q_not_empty;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         if (q_head.op == OP_WRITE) begin
            store_lo[q_head.addr_a] <= q_head.texel;
            store_hi[q_head.addr_a] <= q_head.texel;
         end
         ta_ff <= store_lo[q_head.addr_a];
         tb_ff <= store_lo[q_head.addr_b];
         tc_ff <= store_hi[q_head.addr_c];
         td_ff <= store_hi[q_head.addr_d];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= q_pop && (q_head.op == OP_SAMPLE);
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pa_in[k] = PROD_W'(ta_ff[(2-k)*CLR_W +: CLR_W]) * PROD_W'(wa_ff);
         pb_in[k] = PROD_W'(tb_ff[(2-k)*CLR_W +: CLR_W]) * PROD_W'(wb_ff);
         pc_in[k] = PROD_W'(tc_ff[(2-k)*CLR_W +: CLR_W]) * PROD_W'(wc_ff);
         pd_in[k] = PROD_W'(td_ff[(2-k)*CLR_W +: CLR_W]) * PROD_W'(wd_ff);
         sum[k] = (PROD_W+2)'(pa_ff[k]) + (PROD_W+2)'(pb_ff[k]) +
                  (PROD_W+2)'(pc_ff[k]) + (PROD_W+2)'(pd_ff[k]);
         if (s2_grey_ff) res_in[k] = GREY_OUT;
         else res_in[k] = sum[k][FRAC_W +: OUT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (q_pop) begin
            s1_grey_ff <= q_head.grey;
            wa_ff <= q_head.wt_a;
            wb_ff <= q_head.wt_b;
            wc_ff <= q_head.wt_c;
            wd_ff <= q_head.wt_d;
         end
         s2_grey_ff <= s1_grey_ff;
         for (int k = 0; k < 3; k++) begin
            pa_ff[k]  <= pa_in[k];
            pb_ff[k]  <= pb_in[k];
            pc_ff[k]  <= pc_in[k];
            pd_ff[k]  <= pd_in[k];
            res_ff[k] <= res_in[k];
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign red_out   = res_ff[0];
   assign green_out = res_ff[1];
   assign blue_out  = res_ff[2];
endmodule

### rtl/bilinear_texture_sampler_top.sv
// A sample item passes front stages f1 and f2, the queue, then back stages s1, s2 and result.
// Throughput: one item per clock without output stalls; a write or sample item takes one slot.
// The four texel reads come from two copies of the store, each read at two addresses a cycle.
// Reset clears the size registers to 1 and empties all pipeline and queue control state.
// The texture store is not cleared; an entry must be written before it is sampled.
// Depends on bts_pkg, bts_front, bts_queue and bts_back.
module bilinear_texture_sampler_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // texel_addr[15:0], texel_red[23:16], texel_green[31:24], texel_blue[39:32],
   // u_coord[57:40], v_coord[75:58], zero fill [79:76]
   input  logic [79:0]               req_tdata,
   // op[0], grey_override[1]
   input  logic [1:0]                req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // red_out[15:0], green_out[31:16], blue_out[47:32]
   output logic [47:0]               rsp_tdata,
   input  logic                      csr_we,
   input  logic                      csr_addr,
   input  logic [bts_pkg::REG_W-1:0] csr_wdata
);
   import bts_pkg::*;

   logic              push, pop, not_empty;
   work_type          push_data, head;
   logic [QCNT_W-1:0] q_count;
   logic [OUT_W-1:0]  red, green, blue;

   bts_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .op            (op_type'(req_tuser[0])),
      .grey_override (req_tuser[1]),
      .texel_addr    (req_tdata[15:0]),
      .texel_rgb     ({req_tdata[23:16], req_tdata[31:24], req_tdata[39:32]}),
      .u_coord       (req_tdata[57:40]),
      .v_coord       (req_tdata[75:58]),
      .csr_we        (csr_we),
      .csr_addr      (reg_type'(csr_addr)),
      .csr_wdata     (csr_wdata),
      .q_count       (q_count),
      .push          (push),
      .push_data     (push_data)
   );

   bts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head),
      .count     (q_count)
   );

   bts_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (not_empty),
      .q_head      (head),
      .q_pop       (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .red_out     (red),
      .green_out   (green),
      .blue_out    (blue)
   );

   assign rsp_tdata = {blue, green, red};
endmodule

### tb/bilinear_texture_sampler_top_tb.sv
// Self-checking testbench of bilinear_texture_sampler_top: texel writes, samples and size
// register changes with random stalls on both stream channels, checked by a scoreboard.
// Depends on bts_pkg and the sampler RTL.
module bilinear_texture_sampler_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bts_pkg::*;

   typedef struct {
      logic [OUT_W-1:0] red;
      logic [OUT_W-1:0] green;
      logic [OUT_W-1:0] blue;
   } color_type;

   class texture_scoreboard;
      logic [23:0]     texels [MAX_TEXELS];
      logic [REG_W-1:0] width_reg = 1;
      logic [REG_W-1:0] height_reg = 1;
      color_type       pending [$];
      int              errors = 0;
      int              samples = 0;
      int              writes = 0;

      function int side(logic [REG_W-1:0] r);
         if (r == 0) return 1;
         if (r > MAX_SIDE) return MAX_SIDE;
         return int'(r);
      endfunction

      function void set_reg(reg_type r, logic [REG_W-1:0] v);
         if (r == REG_WIDTH) width_reg = v;
         else height_reg = v;
      endfunction

      function void split(logic [COORD_W-1:0] c, int s, output int lo, output int hi,
                          output int fr);
         int cl;
         logic [31:0] p;
         if (c[COORD_W-1]) cl = 0;
         else if (c > 32768) cl = 32768;
         else cl = int'(c);
         p = cl * (s - 1);
         lo = p >> 15;
         fr = p[14:7];
         hi = lo + (fr != 0);
      endfunction

      function void note_item(op_type op, logic grey, logic [ADDR_W-1:0] addr,
                              logic [23:0] texel, logic [COORD_W-1:0] u,
                              logic [COORD_W-1:0] v);
         int w, xl, xh, s, yl, yh, t;
         logic [23:0] ta, tb, tc, td;
         logic [31:0] sum;
         int wa, wb, wc, wd, k;
         logic [OUT_W-1:0] ch [3];
         if (op == OP_WRITE) begin
            texels[addr] = texel;
            writes++;
            return;
         end
         samples++;
         if (grey) begin
            pending.push_back('{GREY_OUT, GREY_OUT, GREY_OUT});
            return;
         end
         w = side(width_reg);
         split(u, w, xl, xh, s);
         split(v, side(height_reg), yl, yh, t);
         ta = texels[ADDR_W'(yl * w + xl)];
         tb = texels[ADDR_W'(yl * w + xh)];
         tc = texels[ADDR_W'(yh * w + xh)];
         td = texels[ADDR_W'(yh * w + xl)];
         wa = (256 - s) * (256 - t);
         wb = s * (256 - t);
         wc = s * t;
         wd = (256 - s) * t;
         for (k = 0; k < 3; k++) begin
            sum = ta[23-8*k -: 8] * wa + tb[23-8*k -: 8] * wb
                + tc[23-8*k -: 8] * wc + td[23-8*k -: 8] * wd;
            ch[k] = sum[23:8];
         end
         pending.push_back('{ch[0], ch[1], ch[2]});
      endfunction

      function void check_result(logic [47:0] d);
         color_type e;
         if (pending.size() == 0) begin
            $display("%0t: result %h arrived with none expected", $time, d);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (d[15:0] !== e.red) begin
            $display("%0t: red expected %h actual %h", $time, e.red, d[15:0]);
            errors++;
         end
         if (d[31:16] !== e.green) begin
            $display("%0t: green expected %h actual %h", $time, e.green, d[31:16]);
            errors++;
         end
         if (d[47:32] !== e.blue) begin
            $display("%0t: blue expected %h actual %h", $time, e.blue, d[47:32]);
            errors++;
         end
      endfunction
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic             req_tvalid = 0;
   logic             req_tready;
   logic [79:0]      req_tdata = '0;
   logic [1:0]       req_tuser = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 0;
   logic [47:0]      rsp_tdata;
   logic             csr_we = 0;
   logic             csr_addr = 0;
   logic [REG_W-1:0] csr_wdata = '0;

   texture_scoreboard board = new();
   bit  calm = 0;
   int  quiet_cycles = 0;
   int  area = 1;

   bilinear_texture_sampler_top dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
   end

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
      if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send(op_type op, logic grey, logic [ADDR_W-1:0] addr, logic [23:0] texel,
                       logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
      if (!calm && $urandom_range(0, 99) < 25) begin
         req_tvalid = 0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser  = {grey, op};
      req_tdata  = {4'b0, v, u, texel[7:0], texel[15:8], texel[23:16], addr};
      do @(posedge clock); while (!req_tready);
      board.note_item(op, grey, addr, texel, u, v);
      @(negedge clock);
   endtask

   task automatic pause_until_drained();
      req_tvalid = 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic set_size(logic [REG_W-1:0] w, logic [REG_W-1:0] h);
      pause_until_drained();
      csr_we = 1;
      csr_addr = REG_WIDTH;
      csr_wdata = w;
      @(negedge clock);
      csr_addr = REG_HEIGHT;
      csr_wdata = h;
      @(negedge clock);
      csr_we = 0;
      board.set_reg(REG_WIDTH, w);
      board.set_reg(REG_HEIGHT, h);
      area = board.side(w) * board.side(h);
   endtask

   task automatic fill();
      int i;
      for (i = 0; i < area; i++)
         send(OP_WRITE, 1'($urandom), ADDR_W'(i), 24'($urandom), COORD_W'($urandom),
              COORD_W'($urandom));
   endtask

   task automatic random_items(int n);
      int i, r;
      logic [COORD_W-1:0] u, v;
      for (i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         u = (r < 60) ? COORD_W'($urandom_range(0, 32768)) : COORD_W'($urandom);
         v = (r % 3 != 0) ? COORD_W'($urandom_range(0, 32768)) : COORD_W'($urandom);
         if (r < 30)
            send(OP_WRITE, 1'($urandom), ADDR_W'($urandom_range(0, area - 1)),
                 24'($urandom), u, v);
         else if (r < 34)
            send(OP_WRITE, 1'($urandom), ADDR_W'($urandom), 24'($urandom), u, v);
         else
            send(OP_SAMPLE, $urandom_range(0, 99) < 10, ADDR_W'($urandom), 24'($urandom),
                 u, v);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;
      fill();
      send(OP_SAMPLE, 0, 0, 0, 0, 0);
      send(OP_SAMPLE, 0, 0, 0, 18'h1ffff, 18'h20000);
      send(OP_SAMPLE, 1, 16'hffff, 24'hffffff, 18'h3ffff, 18'h3ffff);
      send(OP_WRITE, 1, 16'hffff, 24'hffffff, 18'h3ffff, 18'h3ffff);
      send(OP_WRITE, 0, 16'h0000, 24'h000000, 0, 0);
      send(OP_WRITE, 0, 16'h0001, 24'hffffff, 0, 0);
      set_size(5, 3);
      fill();
      send(OP_WRITE, 0, 16'h0000, 24'hffffff, 0, 0);
      send(OP_SAMPLE, 0, 0, 0, 18'd32768, 18'd32768);
      send(OP_SAMPLE, 0, 0, 0, 18'd32769, 18'd0);
      send(OP_SAMPLE, 0, 0, 0, 18'd16384, 18'd16384);
      send(OP_SAMPLE, 0, 0, 0, 18'd8192, 18'd32767);
      send(OP_SAMPLE, 0, 0, 0, 18'd1, 18'd128);
      send(OP_SAMPLE, 1, 0, 0, 18'd16384, 18'd16384);
      random_items(150);
      calm = 1;
      set_size(0, 0);
      fill();
      random_items(100);
      set_size(2, 256);
      fill();
      random_items(100);
      calm = 0;
      set_size(256, 1);
      fill();
      random_items(100);
      set_size(17, 9);
      fill();
      random_items(100);
      set_size(511, 0);
      random_items(100);
      set_size(300, 2);
      random_items(100);
      set_size(1, 256);
      random_items(75);
      set_size(20, 25);
      random_items(75);
      pause_until_drained();
      repeat (20) @(negedge clock);
      $display("Covered %0d texel writes and %0d samples over ten texture sizes.",
               board.writes, board.samples);
      $display("Mismatches counted: %0d", board.errors);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

### filelist.f
rtl/bts_pkg.sv
rtl/bts_front.sv
rtl/bts_queue.sv
rtl/bts_back.sv
rtl/bilinear_texture_sampler_top.sv
tb/bilinear_texture_sampler_top_tb.sv
